@@ hdl/ik3_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik3_pkg
// Shared types, constants and helper functions of the arm inverse kinematics
// pipeline.
// ----------------------------------------------------------------------------
package ik3_pkg;

  // Default values of the top-level parameters.
  localparam int unsigned COORD_WIDTH_DEF   = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  // Field widths.
  localparam int unsigned LINK_W      = 12;
  localparam int unsigned ANGLE_W     = 14;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OUT_DATA_W  = 48;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 14;

  // CORDIC operand width, fractional pre-scale, datapath and angle widths.
  localparam int unsigned CORDIC_OPW  = 28;
  localparam int unsigned CORDIC_FRAC = 24;
  localparam int unsigned CORDIC_W    = CORDIC_OPW + 1 + CORDIC_FRAC + 2;
  localparam int unsigned ACC_W       = 26;
  localparam int unsigned ATAN_W      = 22;
  localparam int unsigned DEG_W       = 18;
  localparam int unsigned ACC_QUARTER = 5898240;  // 90 degrees in 1/65536 degree
  localparam int unsigned DEG_ROUND   = 512;
  localparam int unsigned HALF_TURN   = 11520;    // 180 degrees in 1/64 degree

  // Square root unit.
  localparam int unsigned SQRT_W   = 50;
  localparam int unsigned SQRT_LAT = SQRT_W / 2;
  localparam int unsigned ROOT_W   = SQRT_W / 2;

  // Reach check constants.
  localparam logic [63:0] FAR_LIMIT = 64'd1 << 40;
  localparam logic [63:0] T_BIG     = 64'd1 << 18;
  localparam int unsigned MEGA      = 1000000;
  localparam int unsigned FAR_NUM   = 2001;
  localparam int unsigned NEAR_NUM  = 1999;

  // Register reset values.
  localparam logic [LINK_W-1:0]  UPPER_LEN_RST = 12'd1280;
  localparam logic [LINK_W-1:0]  LOWER_LEN_RST = 12'd1840;
  localparam logic [ANGLE_W-1:0] BASE_MIN_RST  = 14'd0;
  localparam logic [ANGLE_W-1:0] BASE_MAX_RST  = 14'd11520;
  localparam logic [ANGLE_W-1:0] SH_MIN_RST    = 14'd0;
  localparam logic [ANGLE_W-1:0] SH_MAX_RST    = 14'd7680;
  localparam logic [ANGLE_W-1:0] EL_MIN_RST    = 14'd0;
  localparam logic [ANGLE_W-1:0] EL_MAX_RST    = 14'd7680;

  typedef enum logic [STATUS_W-1:0] {
    ST_SOLVED = 2'd0,
    ST_BELOW  = 2'd1,
    ST_FAR    = 2'd2,
    ST_NEAR   = 2'd3
  } ik_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_UPPER_LEN = 3'd0,
    REG_LOWER_LEN = 3'd1,
    REG_BASE_MIN  = 3'd2,
    REG_BASE_MAX  = 3'd3,
    REG_SH_MIN    = 3'd4,
    REG_SH_MAX    = 3'd5,
    REG_EL_MIN    = 3'd6,
    REG_EL_MAX    = 3'd7
  } cfg_reg_t;

  // Micro-rotation angle atan(2^-i) in 1/65536 degree, rounded.
  function automatic logic [ATAN_W-1:0] atan_step(input int unsigned idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      0:  v = 22'd2949120;
      1:  v = 22'd1740967;
      2:  v = 22'd919879;
      3:  v = 22'd466945;
      4:  v = 22'd234379;
      5:  v = 22'd117304;
      6:  v = 22'd58666;
      7:  v = 22'd29335;
      8:  v = 22'd14668;
      9:  v = 22'd7334;
      10: v = 22'd3667;
      11: v = 22'd1833;
      12: v = 22'd917;
      13: v = 22'd458;
      14: v = 22'd229;
      15: v = 22'd115;
      16: v = 22'd57;
      17: v = 22'd29;
      18: v = 22'd14;
      19: v = 22'd7;
      20: v = 22'd4;
      21: v = 22'd2;
      22: v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // 1/65536 degree to 1/64 degree, rounded half up.
  function automatic logic signed [DEG_W-1:0] to_deg(input logic signed [ACC_W:0] a);
    logic signed [ACC_W:0] t;
    t = a + (ACC_W+1)'(DEG_ROUND);
    return DEG_W'(t >>> 10);
  endfunction

endpackage

@@ hdl/ik3_isqrt.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik3_isqrt
// Pipelined integer square root, one result bit per register stage.
// ----------------------------------------------------------------------------
module ik3_isqrt import ik3_pkg::*; #(
  parameter int unsigned W = SQRT_W
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [W-1:0]   in_val,
  output logic           out_vld,
  output logic [W/2-1:0] out_root
);

  localparam int unsigned STEPS = W / 2;

  logic [W-1:0] rem_r  [0:STEPS-1];
  logic [W-1:0] root_r [0:STEPS-1];
  logic         vld_r  [0:STEPS-1];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam logic [W:0] BIT = (W+1)'(1) << (W - 2 - 2 * k);
    logic [W-1:0] rem_i, root_i, rem_nxt, root_nxt;
    logic         vld_i;
    logic [W:0]   trial;

    if (k == 0) begin : g_first
      assign rem_i  = in_val;
      assign root_i = '0;
      assign vld_i  = in_vld;
    end else begin : g_next
      assign rem_i  = rem_r[k-1];
      assign root_i = root_r[k-1];
      assign vld_i  = vld_r[k-1];
    end

    always_comb begin
      trial = {1'b0, root_i} + BIT;
      if ({1'b0, rem_i} >= trial) begin
        rem_nxt  = rem_i - trial[W-1:0];
        root_nxt = (root_i >> 1) + BIT[W-1:0];
      end else begin
        rem_nxt  = rem_i;
        root_nxt = root_i >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign out_vld  = vld_r[STEPS-1];
  assign out_root = root_r[STEPS-1][W/2-1:0];

endmodule

@@ hdl/ik3_cordic.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ik3_cordic
// Pipelined vectoring CORDIC giving atan2(y, x) in 1/65536 degree.
// ----------------------------------------------------------------------------
module ik3_cordic import ik3_pkg::*; #(
  parameter int unsigned STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic signed [CORDIC_OPW-1:0] in_y,
  input  logic signed [CORDIC_OPW-1:0] in_x,
  output logic                    out_vld,
  output logic signed [ACC_W-1:0] out_acc
);

  localparam logic signed [ACC_W-1:0] QTR = ACC_W'(ACC_QUARTER);
  localparam int unsigned EXT_W = CORDIC_W - CORDIC_OPW - 1 - CORDIC_FRAC;

  logic signed [CORDIC_W-1:0] x_r   [0:STAGES];
  logic signed [CORDIC_W-1:0] y_r   [0:STAGES];
  logic signed [ACC_W-1:0]    acc_r [0:STAGES];
  logic                       spc_r [0:STAGES];
  logic                       vld_r [0:STAGES];

  // Entry: axis cases are resolved outright, the left half-plane is
  // rotated by a quarter turn, and the operands are pre-scaled.
  logic signed [CORDIC_OPW:0] xs, ys;
  logic signed [ACC_W-1:0]    a0;
  logic                       spc;

  always_comb begin
    spc = 1'b0;
    a0  = '0;
    xs  = (CORDIC_OPW+1)'(in_x);
    ys  = (CORDIC_OPW+1)'(in_y);
    if (in_y == '0) begin
      spc = 1'b1;
      a0  = (in_x >= 0) ? '0 : QTR + QTR;
    end else if (in_x == '0) begin
      spc = 1'b1;
      a0  = (in_y > 0) ? QTR : -QTR;
    end else if (in_x < 0) begin
      if (in_y >= 0) begin
        xs = (CORDIC_OPW+1)'(in_y);
        ys = -((CORDIC_OPW+1)'(in_x));
        a0 = QTR;
      end else begin
        xs = -((CORDIC_OPW+1)'(in_y));
        ys = (CORDIC_OPW+1)'(in_x);
        a0 = -QTR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= {{EXT_W{xs[CORDIC_OPW]}}, xs, {CORDIC_FRAC{1'b0}}};
      y_r[0]   <= {{EXT_W{ys[CORDIC_OPW]}}, ys, {CORDIC_FRAC{1'b0}}};
      acc_r[0] <= a0;
      spc_r[0] <= spc;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic signed [ACC_W-1:0] ANG = ACC_W'(atan_step(i));
    logic signed [CORDIC_W-1:0] dx, dy, x_nxt, y_nxt;
    logic signed [ACC_W-1:0]    acc_nxt;

    always_comb begin
      dx = y_r[i] >>> i;
      dy = x_r[i] >>> i;
      if (y_r[i] >= 0) begin
        x_nxt   = x_r[i] + dx;
        y_nxt   = y_r[i] - dy;
        acc_nxt = acc_r[i] + ANG;
      end else begin
        x_nxt   = x_r[i] - dx;
        y_nxt   = y_r[i] + dy;
        acc_nxt = acc_r[i] - ANG;
      end
      if (spc_r[i]) begin
        acc_nxt = acc_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1]   <= x_nxt;
        y_r[i+1]   <= y_nxt;
        acc_r[i+1] <= acc_nxt;
        spc_r[i+1] <= spc_r[i];
      end
    end
  end

  assign out_vld = vld_r[STAGES];
  assign out_acc = acc_r[STAGES];

endmodule

@@ hdl/three_dof_arm_inverse_kinematics.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_dof_arm_inverse_kinematics
// Turns a target point into base, shoulder and elbow servo angles.
// ----------------------------------------------------------------------------
// A target word enters on the in_ channel: in_tdata carries target_x, target_y
// and target_z, each a signed COORD_WIDTH-bit value in 1/16 mm. One result
// word leaves on the out_ channel for every target: out_tuser is the solve
// status and out_tdata the three angles in 1/64 degree.
// Link lengths and angle limits sit behind the cfg_ write channel, which is
// always ready; they should only be written while no target is in flight.
// The datapath is one long pipeline: six stages of squares and reach checks,
// a 25-stage square root, a CORDIC of CORDIC_STAGES+1 stages and two stages
// of rounding and clamping. A new target is taken every cycle while no
// result is stalled at the output. When the receiver holds out_tready low
// with a result waiting, the whole pipeline freezes in place and in_tready
// drops until the result is taken. Reset empties the pipeline and loads the
// register defaults.
// ----------------------------------------------------------------------------
module three_dof_arm_inverse_kinematics import ik3_pkg::*; #(
  parameter int unsigned CORDIC_STAGES = CORDIC_STAGES_DEF,
  parameter int unsigned COORD_WIDTH   = COORD_WIDTH_DEF,
  localparam int unsigned IN_W = ((3 * COORD_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,   // target_x, target_y, target_z
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // base_angle, shoulder_angle, elbow_angle
  output logic [STATUS_W-1:0]   out_tuser,  // solve_status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned SQ_W = 2 * CW;      // one coordinate squared
  localparam int unsigned RR_W = 2 * CW + 1;  // x^2 + y^2
  localparam int unsigned D2_W = 2 * CW + 2;  // x^2 + y^2 + z^2
  localparam int unsigned N_W  = D2_W + 1;    // d^2 - L1^2 - L2^2, signed
  localparam int unsigned PAD_W = OUT_DATA_W - 3 * ANGLE_W;

  // Items waiting behind the square root and behind the CORDIC.
  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
    logic signed [25:0]   nc;
    logic signed [26:0]   x2;
    logic                 below;
    logic                 axis0;
    logic                 far;
    logic                 near;
  } side1_t;

  typedef struct packed {
    logic below;
    logic axis0;
    logic far;
    logic near;
  } side2_t;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [LINK_W-1:0]  l1_r, l2_r;
  logic [ANGLE_W-1:0] bmin_r, bmax_r, smin_r, smax_r, emin_r, emax_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      l1_r   <= UPPER_LEN_RST;
      l2_r   <= LOWER_LEN_RST;
      bmin_r <= BASE_MIN_RST;
      bmax_r <= BASE_MAX_RST;
      smin_r <= SH_MIN_RST;
      smax_r <= SH_MAX_RST;
      emin_r <= EL_MIN_RST;
      emax_r <= EL_MAX_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_UPPER_LEN: l1_r   <= cfg_data[LINK_W-1:0];
        REG_LOWER_LEN: l2_r   <= cfg_data[LINK_W-1:0];
        REG_BASE_MIN:  bmin_r <= cfg_data[ANGLE_W-1:0];
        REG_BASE_MAX:  bmax_r <= cfg_data[ANGLE_W-1:0];
        REG_SH_MIN:    smin_r <= cfg_data[ANGLE_W-1:0];
        REG_SH_MAX:    smax_r <= cfg_data[ANGLE_W-1:0];
        REG_EL_MIN:    emin_r <= cfg_data[ANGLE_W-1:0];
        REG_EL_MAX:    emax_r <= cfg_data[ANGLE_W-1:0];
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline advance: every stage moves unless a finished word is stuck at
  // the output.
  // --------------------------------------------------------------------------
  logic out_valid_r;
  logic en;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  logic vld_a_r, vld_b_r, vld_c_r, vld_d_r, vld_e_r, vld_f_r, vld_g_r;
  logic sq_vld, crd_vld;
  logic sq_vld_sin, sq_vld_reach;
  logic crd_vld_base, crd_vld_el, crd_vld_rise, crd_vld_fold;

  // --------------------------------------------------------------------------
  // Stage A: unpack and square
  // --------------------------------------------------------------------------
  logic signed [CW-1:0]   xi, yi, zi;
  logic signed [SQ_W-1:0] xsq, ysq, zsq;

  assign xi  = $signed(in_tdata[CW-1:0]);
  assign yi  = $signed(in_tdata[2*CW-1:CW]);
  assign zi  = $signed(in_tdata[3*CW-1:2*CW]);
  assign xsq = SQ_W'(xi) * SQ_W'(xi);
  assign ysq = SQ_W'(yi) * SQ_W'(yi);
  assign zsq = SQ_W'(zi) * SQ_W'(zi);

  logic signed [CW-1:0] x_a_r, y_a_r, z_a_r;
  logic [SQ_W-1:0]      xx_a_r, yy_a_r, zz_a_r;
  logic [23:0]          l1sq_a_r, l2sq_a_r, l1l2_a_r;
  logic [12:0]          s_a_r;
  logic [11:0]          dd_a_r;
  logic                 below_a_r, axis0_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_a_r     <= xi;
      y_a_r     <= yi;
      z_a_r     <= zi;
      xx_a_r    <= $unsigned(xsq);
      yy_a_r    <= $unsigned(ysq);
      zz_a_r    <= $unsigned(zsq);
      l1sq_a_r  <= 24'(l1_r) * 24'(l1_r);
      l2sq_a_r  <= 24'(l2_r) * 24'(l2_r);
      l1l2_a_r  <= 24'(l1_r) * 24'(l2_r);
      s_a_r     <= 13'(l1_r) + 13'(l2_r);
      dd_a_r    <= (l1_r >= l2_r) ? (l1_r - l2_r) : (l2_r - l1_r);
      below_a_r <= (xi == '0) && (yi == '0) && (zi < 0);
      axis0_a_r <= (xi == '0) && (yi == '0);
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: distances and link terms
  // --------------------------------------------------------------------------
  logic signed [CW-1:0] x_b_r, y_b_r, z_b_r;
  logic [RR_W-1:0]      rr_b_r;
  logic [D2_W-1:0]      d2_b_r;
  logic [25:0]          ss_b_r;
  logic [23:0]          dd2_b_r, l1sq_b_r;
  logic [24:0]          p_b_r, ll_b_r;
  logic                 below_b_r, axis0_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_b_r     <= x_a_r;
      y_b_r     <= y_a_r;
      z_b_r     <= z_a_r;
      rr_b_r    <= RR_W'(xx_a_r) + RR_W'(yy_a_r);
      d2_b_r    <= D2_W'(xx_a_r) + D2_W'(yy_a_r) + D2_W'(zz_a_r);
      ss_b_r    <= 26'(s_a_r) * 26'(s_a_r);
      dd2_b_r   <= 24'(dd_a_r) * 24'(dd_a_r);
      p_b_r     <= {l1l2_a_r, 1'b0};
      ll_b_r    <= 25'(l1sq_a_r) + 25'(l2sq_a_r);
      l1sq_b_r  <= l1sq_a_r;
      below_b_r <= below_a_r;
      axis0_b_r <= axis0_a_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: reach differences. The 0.1% margins are checked as
  // 10^6 (d^2 - S^2) > 2001 S^2 and 10^6 (D^2 - d^2) > 1999 D^2, which keeps
  // every product narrow.
  // --------------------------------------------------------------------------
  logic [63:0] d2w, ssw, dd2w;

  assign d2w  = 64'(d2_b_r);
  assign ssw  = 64'(ss_b_r);
  assign dd2w = 64'(dd2_b_r);

  logic signed [CW-1:0]  x_c_r, y_c_r, z_c_r;
  logic [RR_W-1:0]       rr_c_r;
  logic                  far0_c_r, tpos_c_r, tbig_c_r, upos_c_r;
  logic [17:0]           tlow_c_r;
  logic [23:0]           u_c_r, dd2_c_r, l1sq_c_r;
  logic signed [N_W-1:0] n_c_r;
  logic [24:0]           p_c_r;
  logic [25:0]           ss_c_r;
  logic                  below_c_r, axis0_c_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_c_r     <= x_b_r;
      y_c_r     <= y_b_r;
      z_c_r     <= z_b_r;
      rr_c_r    <= rr_b_r;
      far0_c_r  <= d2w >= FAR_LIMIT;
      tpos_c_r  <= d2w > ssw;
      tbig_c_r  <= d2w >= ssw + T_BIG;
      tlow_c_r  <= 18'(d2w - ssw);
      upos_c_r  <= dd2w > d2w;
      u_c_r     <= 24'(dd2w - d2w);
      n_c_r     <= $signed(N_W'(d2_b_r)) - $signed(N_W'(ll_b_r));
      p_c_r     <= p_b_r;
      ss_c_r    <= ss_b_r;
      dd2_c_r   <= dd2_b_r;
      l1sq_c_r  <= l1sq_b_r;
      below_c_r <= below_b_r;
      axis0_c_r <= axis0_b_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: margin products and the cosine clamp to +-2 L1 L2
  // --------------------------------------------------------------------------
  logic signed [N_W-1:0] pw, nc;

  always_comb begin
    pw = $signed(N_W'(p_c_r));
    if (n_c_r > pw) begin
      nc = pw;
    end else if (n_c_r < -pw) begin
      nc = -pw;
    end else begin
      nc = n_c_r;
    end
  end

  logic signed [CW-1:0] x_d_r, y_d_r, z_d_r;
  logic [RR_W-1:0]      rr_d_r;
  logic [37:0]          prodt_d_r;
  logic [36:0]          prods_d_r;
  logic [43:0]          produ_d_r;
  logic [34:0]          prodd_d_r;
  logic                 far0_d_r, tpos_d_r, tbig_d_r, upos_d_r;
  logic signed [25:0]   nc_d_r;
  logic [24:0]          p_d_r;
  logic [23:0]          l1sq_d_r;
  logic                 below_d_r, axis0_d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_d_r     <= x_c_r;
      y_d_r     <= y_c_r;
      z_d_r     <= z_c_r;
      rr_d_r    <= rr_c_r;
      prodt_d_r <= 38'(tlow_c_r) * 38'(MEGA);
      prods_d_r <= 37'(ss_c_r) * 37'(FAR_NUM);
      produ_d_r <= 44'(u_c_r) * 44'(MEGA);
      prodd_d_r <= 35'(dd2_c_r) * 35'(NEAR_NUM);
      far0_d_r  <= far0_c_r;
      tpos_d_r  <= tpos_c_r;
      tbig_d_r  <= tbig_c_r;
      upos_d_r  <= upos_c_r;
      nc_d_r    <= 26'(nc);
      p_d_r     <= p_c_r;
      l1sq_d_r  <= l1sq_c_r;
      below_d_r <= below_c_r;
      axis0_d_r <= axis0_c_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage E: reach verdict, squares for the sine term, second atan2 abscissa
  // --------------------------------------------------------------------------
  logic signed [51:0] ncsq;

  assign ncsq = 52'(nc_d_r) * 52'(nc_d_r);

  logic signed [CW-1:0] x_e_r, y_e_r, z_e_r;
  logic [RR_W-1:0]      rr_e_r;
  logic                 far_e_r, near_e_r;
  logic [49:0]          nn_e_r, pp_e_r;
  logic signed [26:0]   x2_e_r;
  logic signed [25:0]   nc_e_r;
  logic                 below_e_r, axis0_e_r;

  always_ff @(posedge clk) begin
    if (en) begin
      x_e_r     <= x_d_r;
      y_e_r     <= y_d_r;
      z_e_r     <= z_d_r;
      rr_e_r    <= rr_d_r;
      far_e_r   <= far0_d_r || (tpos_d_r && (tbig_d_r || (prodt_d_r > 38'(prods_d_r))));
      near_e_r  <= upos_d_r && (produ_d_r > 44'(prodd_d_r));
      nn_e_r    <= ncsq[49:0];
      pp_e_r    <= 50'(p_d_r) * 50'(p_d_r);
      x2_e_r    <= $signed({2'b00, l1sq_d_r, 1'b0}) + 27'(nc_d_r);
      nc_e_r    <= nc_d_r;
      below_e_r <= below_d_r;
      axis0_e_r <= axis0_d_r;
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: radicand of (2 L1 L2 sin e)
  // --------------------------------------------------------------------------
  logic [49:0]     rad_f_r;
  logic [RR_W-1:0] rr_f_r;
  side1_t          s1_f_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rad_f_r       <= pp_e_r - nn_e_r;
      rr_f_r        <= rr_e_r;
      s1_f_r.x      <= x_e_r;
      s1_f_r.y      <= y_e_r;
      s1_f_r.z      <= z_e_r;
      s1_f_r.nc     <= nc_e_r;
      s1_f_r.x2     <= x2_e_r;
      s1_f_r.below  <= below_e_r;
      s1_f_r.axis0  <= axis0_e_r;
      s1_f_r.far    <= far_e_r;
      s1_f_r.near   <= near_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
      vld_d_r <= 1'b0;
      vld_e_r <= 1'b0;
      vld_f_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_tvalid;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
      vld_d_r <= vld_c_r;
      vld_e_r <= vld_d_r;
      vld_f_r <= vld_e_r;
    end
  end

  // --------------------------------------------------------------------------
  // Square roots: the sine term and the horizontal reach sqrt(x^2 + y^2)
  // --------------------------------------------------------------------------
  logic [ROOT_W-1:0] m_root, r_root;

  ik3_isqrt #(.W(SQRT_W)) u_sqrt_sin (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_f_r),
    .in_val   (rad_f_r),
    .out_vld  (sq_vld_sin),
    .out_root (m_root)
  );

  ik3_isqrt #(.W(SQRT_W)) u_sqrt_reach (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (vld_f_r),
    .in_val   (SQRT_W'(rr_f_r)),
    .out_vld  (sq_vld_reach),
    .out_root (r_root)
  );

  // Both roots run in lockstep, so their valid bits always agree.
  assign sq_vld = sq_vld_sin && sq_vld_reach;

  side1_t sd1_r [0:SQRT_LAT-1];
  side1_t s1;

  always_ff @(posedge clk) begin
    if (en) begin
      sd1_r[0] <= s1_f_r;
      for (int k = 1; k < SQRT_LAT; k++) begin
        sd1_r[k] <= sd1_r[k-1];
      end
    end
  end

  assign s1 = sd1_r[SQRT_LAT-1];

  // --------------------------------------------------------------------------
  // Four CORDIC units: base yaw, elbow, and the two shoulder terms
  // --------------------------------------------------------------------------
  logic signed [CORDIC_OPW-1:0] m_op, r_op;
  logic signed [ACC_W-1:0]      acc_base, acc_el, acc_sh1, acc_sh2;

  assign m_op = $signed(CORDIC_OPW'(m_root));
  assign r_op = $signed(CORDIC_OPW'(r_root));

  ik3_cordic #(.STAGES(CORDIC_STAGES)) u_crd_base (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (sq_vld),
    .in_y (CORDIC_OPW'(s1.y)), .in_x (CORDIC_OPW'(s1.x)),
    .out_vld (crd_vld_base), .out_acc (acc_base)
  );

  ik3_cordic #(.STAGES(CORDIC_STAGES)) u_crd_elbow (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (sq_vld),
    .in_y (m_op), .in_x (CORDIC_OPW'(s1.nc)),
    .out_vld (crd_vld_el), .out_acc (acc_el)
  );

  ik3_cordic #(.STAGES(CORDIC_STAGES)) u_crd_rise (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (sq_vld),
    .in_y (CORDIC_OPW'(s1.z)), .in_x (r_op),
    .out_vld (crd_vld_rise), .out_acc (acc_sh1)
  );

  ik3_cordic #(.STAGES(CORDIC_STAGES)) u_crd_fold (
    .clk (clk), .rst_n (rst_n), .en (en), .in_vld (sq_vld),
    .in_y (m_op), .in_x (CORDIC_OPW'(s1.x2)),
    .out_vld (crd_vld_fold), .out_acc (acc_sh2)
  );

  // The four rotators share one timing, so their valid bits always agree.
  assign crd_vld = crd_vld_base && crd_vld_el && crd_vld_rise && crd_vld_fold;

  side2_t sd2_r [0:CORDIC_STAGES];
  side2_t s2;

  always_ff @(posedge clk) begin
    if (en) begin
      sd2_r[0] <= '{below: s1.below, axis0: s1.axis0, far: s1.far, near: s1.near};
      for (int k = 1; k <= CORDIC_STAGES; k++) begin
        sd2_r[k] <= sd2_r[k-1];
      end
    end
  end

  assign s2 = sd2_r[CORDIC_STAGES];

  // --------------------------------------------------------------------------
  // Stage G: angles to 1/64 degree. The shoulder is rounded once, after the
  // two terms are summed. A point straight above the origin has yaw zero.
  // --------------------------------------------------------------------------
  logic signed [DEG_W-1:0] bdeg_g_r, sdeg_g_r, edeg_g_r;
  side2_t                  s2_g_r;

  always_ff @(posedge clk) begin
    if (en) begin
      bdeg_g_r <= s2.axis0 ? '0 : to_deg((ACC_W+1)'(acc_base));
      sdeg_g_r <= to_deg((ACC_W+1)'(acc_sh1) + (ACC_W+1)'(acc_sh2));
      edeg_g_r <= to_deg((ACC_W+1)'(acc_el));
      s2_g_r   <= s2;
    end
  end

  // --------------------------------------------------------------------------
  // Output stage: yaw fold, clamps and status
  // --------------------------------------------------------------------------
  logic signed [DEG_W-1:0] bfold, bcl, scl, ecl;
  ik_status_t              status_nxt;

  always_comb begin
    bfold = (bdeg_g_r < 0) ? bdeg_g_r + DEG_W'(HALF_TURN) : bdeg_g_r;
    bcl   = bfold;
    if (bcl > $signed(DEG_W'(bmax_r))) bcl = $signed(DEG_W'(bmax_r));
    if (bcl < $signed(DEG_W'(bmin_r))) bcl = $signed(DEG_W'(bmin_r));
    // Joint clamps: min first, then max, so the max wins when they cross.
    scl = sdeg_g_r;
    if (scl < $signed(DEG_W'(smin_r))) scl = $signed(DEG_W'(smin_r));
    if (scl > $signed(DEG_W'(smax_r))) scl = $signed(DEG_W'(smax_r));
    ecl = edeg_g_r;
    if (ecl < $signed(DEG_W'(emin_r))) ecl = $signed(DEG_W'(emin_r));
    if (ecl > $signed(DEG_W'(emax_r))) ecl = $signed(DEG_W'(emax_r));

    if (s2_g_r.below) begin
      status_nxt = ST_BELOW;
    end else if (s2_g_r.far) begin
      status_nxt = ST_FAR;
    end else if (s2_g_r.near) begin
      status_nxt = ST_NEAR;
    end else begin
      status_nxt = ST_SOLVED;
    end
  end

  ik_status_t         out_status_r;
  logic [ANGLE_W-1:0] out_base_r, out_sh_r, out_el_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_g_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      vld_g_r     <= crd_vld;
      out_valid_r <= vld_g_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_status_r <= status_nxt;
      out_base_r   <= (status_nxt == ST_BELOW) ? '0 : bcl[ANGLE_W-1:0];
      out_sh_r     <= (status_nxt == ST_SOLVED) ? scl[ANGLE_W-1:0] : '0;
      out_el_r     <= (status_nxt == ST_SOLVED) ? ecl[ANGLE_W-1:0] : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_el_r, out_sh_r, out_base_r};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
`ifndef SYNTH
  // A target below the origin reports no angles at all.
  a_below_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_BELOW)) |-> (out_tdata == '0))
    else $error("below-origin result carries nonzero angles");

  // An unreachable target keeps its yaw but reports no joint angles.
  a_reach_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ((out_tuser == ST_FAR) || (out_tuser == ST_NEAR)))
      |-> (out_tdata[OUT_DATA_W-1:ANGLE_W] == '0))
    else $error("out-of-reach result carries joint angles");

  // A solved result never exceeds the joint upper limits.
  a_joint_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == ST_SOLVED))
      |-> ((out_tdata[2*ANGLE_W-1:ANGLE_W] <= smax_r) &&
           (out_tdata[3*ANGLE_W-1:2*ANGLE_W] <= emax_r)))
    else $error("joint angle above its configured limit");
`endif

endmodule
